@@ hdl/ipd_pkg.sv @@
package ipd_pkg;

  localparam int WORD_W  = 16;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 21;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 21;

  // Upper bound on decoded values per stream
  localparam logic [CNT_W-1:0] MAX_OUTPUTS = CNT_W'(1048576);

  // Mode bit 0 selects 16-bit words, bit 1 selects signed words
  typedef enum logic [MODE_W-1:0] {
    MODE_U8  = 2'd0,
    MODE_U16 = 2'd1,
    MODE_S8  = 2'd2,
    MODE_S16 = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_MANY  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_TOO_FEW   = 2'd3
  } status_t;

  typedef enum logic {
    REG_MODE           = 1'b0,
    REG_EXPECTED_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              last_word;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic             value_valid;
    logic             done_res;
    status_t          status;
  } out_t;

  // Decoded form of one packed word
  typedef struct packed {
    logic [SUM_W-1:0] ext;
    logic             cont;
    logic             last;
  } word_t;

endpackage

@@ hdl/ipd_word_dec.sv @@
module ipd_word_dec (
  input  ipd_pkg::in_t   in_data,
  input  ipd_pkg::mode_t mode,
  output ipd_pkg::word_t word
);
  import ipd_pkg::*;

  logic              wide;
  logic              sgn;
  logic [7:0]        lo;
  logic [WORD_W-1:0] hw;

  assign wide = (mode == MODE_U16) || (mode == MODE_S16);
  assign sgn  = (mode == MODE_S8) || (mode == MODE_S16);
  assign lo   = in_data.packed_word[7:0];
  assign hw   = in_data.packed_word;

  always_comb begin
    word.last = in_data.last_word;
    if (wide) begin
      word.ext = sgn ? {{(SUM_W-WORD_W){hw[WORD_W-1]}}, hw} : {{(SUM_W-WORD_W){1'b0}}, hw};
      if (sgn) begin
        word.cont = (hw == 16'h8000) || (hw == 16'h7FFF);
      end else begin
        word.cont = (hw == 16'hFFFF);
      end
    end else begin
      word.ext = sgn ? {{(SUM_W-8){lo[7]}}, lo} : {{(SUM_W-8){1'b0}}, lo};
      if (sgn) begin
        word.cont = (lo == 8'h80) || (lo == 8'h7F);
      end else begin
        word.cont = (lo == 8'hFF);
      end
    end
  end

endmodule

@@ hdl/ipd_run_ctl.sv @@
module ipd_run_ctl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  ipd_pkg::word_t                word,
  input  logic [ipd_pkg::CNT_W-1:0]     expected_count,
  output logic                          res_fire,
  output ipd_pkg::out_t                 res
);
  import ipd_pkg::*;

  logic [SUM_W-1:0] run_sum, run_sum_next;
  logic             in_run, in_run_next;
  logic [CNT_W-1:0] emitted_count, emitted_count_next;
  status_t          error_code, error_code_next;

  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_inc;
  logic [SUM_W-1:0] sum;

  assign limit   = (expected_count > MAX_OUTPUTS) ? MAX_OUTPUTS : expected_count;
  assign cnt_inc = emitted_count + CNT_W'(1);
  assign sum     = in_run ? (run_sum + word.ext) : word.ext;

  always_comb begin
    run_sum_next       = run_sum;
    in_run_next        = in_run;
    emitted_count_next = emitted_count;
    error_code_next    = error_code;
    res_fire           = 1'b0;
    res                = '{value: '0, value_valid: 1'b0, done_res: 1'b0, status: ST_OK};
    if (error_code != ST_OK) begin
      // Latched error: stay silent until the last word
      if (word.last) begin
        res_fire        = 1'b1;
        res.done_res    = 1'b1;
        res.status      = error_code;
      end
    end else if (word.cont) begin
      if (word.last) begin
        res_fire     = 1'b1;
        res.done_res = 1'b1;
        res.status   = ST_TRUNCATED;
      end else begin
        run_sum_next = sum;
        in_run_next  = 1'b1;
      end
    end else begin
      run_sum_next = '0;
      in_run_next  = 1'b0;
      if (emitted_count >= limit) begin
        if (word.last) begin
          res_fire     = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_TOO_MANY;
        end else begin
          error_code_next = ST_TOO_MANY;
        end
      end else begin
        emitted_count_next = cnt_inc;
        res_fire           = 1'b1;
        res.value          = sum;
        res.value_valid    = 1'b1;
        if (word.last) begin
          res.done_res = 1'b1;
          res.status   = (cnt_inc == limit) ? ST_OK : ST_TOO_FEW;
        end
      end
    end
    // Last word always ends the stream: clear for the next one
    if (word.last) begin
      run_sum_next       = '0;
      in_run_next        = 1'b0;
      emitted_count_next = '0;
      error_code_next    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum       <= '0;
      in_run        <= 1'b0;
      emitted_count <= '0;
      error_code    <= ST_OK;
    end else if (take) begin
      run_sum       <= run_sum_next;
      in_run        <= in_run_next;
      emitted_count <= emitted_count_next;
      error_code    <= error_code_next;
    end
  end

endmodule

@@ hdl/integer_packing_decoder_unit.sv @@
// Packed-integer run decoder.
//
// Input channel (in_valid/in_ready/in_data) carries one packed word per
// transfer plus a flag marking the last word of a stream. Output channel
// (out_valid/out_ready/out_item) carries at most one result per input word:
// a decoded 32-bit value when a run closes, and on the last word a done flag
// with the stream status.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data):
// index 0 sets the word mode, index 1 the expected value count. Write only
// while no transfer is in flight.
// A result appears on out_valid in the cycle after its input transfer.
// Throughput: one word per cycle while out_ready does not stall the output;
// the running sum and count update in a single add-and-compare step between
// the input handshake and the output register.
// Stall: the output register holds its result while out_ready is low; a new
// word is still taken in the cycle that the held result is transferred.
// Reset (rst, synchronous) clears the configuration to unsigned 8-bit mode
// with a count of zero, empties the output register and clears the stream.
module integer_packing_decoder_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [ipd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ipd_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ipd_pkg::out_t              out_item
);
  import ipd_pkg::*;

  mode_t            mode;
  logic [CNT_W-1:0] expected_count;

  word_t word;
  logic  take;
  logic  res_fire;
  out_t  res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_U8;
      expected_count <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:           mode           <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_EXPECTED_COUNT: expected_count <= cfg_data[CNT_W-1:0];
        default:            ;
      endcase
    end
  end

  // Accept whenever the output register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  ipd_word_dec u_word_dec (
    .in_data (in_data),
    .mode    (mode),
    .word    (word)
  );

  ipd_run_ctl u_run_ctl (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .word           (word),
    .expected_count (expected_count),
    .res_fire       (res_fire),
    .res            (res)
  );

  // Output register: load on every free cycle, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= take && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= res;
    end
  end

endmodule
